// File: rtl/isc_pkg.sv
// Package for the index stream primitive converter.
// Holds widths, register and mode codes, shared types and the per-index
// expansion functions. No dependencies.
`default_nettype none

package isc_pkg;

  // Widths and sizes
  localparam int IDX_W         = 32;
  localparam int HALF_W        = 16;
  localparam int QUAD_SIZE     = 4;
  localparam int TRI_PAIR_SIZE = 6;
  localparam int HOLD_DEPTH    = QUAD_SIZE - 1;
  localparam int CNT_W         = $clog2(TRI_PAIR_SIZE + 1);
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 8;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_WIDE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRIM_MODE  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GENERATE   = 2'd3;

  // Byte swap codes
  localparam logic [1:0] SWAP_NONE = 2'd0;
  localparam logic [1:0] SWAP_HALF = 2'd1;
  localparam logic [1:0] SWAP_WORD = 2'd2;

  // Primitive conversion codes
  localparam logic [1:0] PRIM_PASS = 2'd0;
  localparam logic [1:0] PRIM_QUAD = 2'd1;
  localparam logic [1:0] PRIM_LOOP = 2'd2;

  typedef logic [IDX_W-1:0] index_t;

  typedef struct packed {
    logic       index_wide;
    logic [1:0] byte_order;
    logic [1:0] prim_mode;
    logic       generate_indices;
  } cfg_t;

  // Primitive tracking state
  typedef struct packed {
    index_t [HOLD_DEPTH-1:0] hold;
    logic [1:0]              fill;
    index_t                  loop_first;
    logic                    first_seen;
  } prim_state_t;

  // Group of results produced by one input transaction
  typedef struct packed {
    logic [CNT_W-1:0]                 count;
    index_t [TRI_PAIR_SIZE-1:0]       idx;
    logic [TRI_PAIR_SIZE-1:0]         eor;
  } batch_t;

  typedef struct packed {
    prim_state_t st;
    batch_t      res;
  } take_t;

  function automatic index_t swap_word(index_t w, logic [1:0] mode);
    index_t r;
    case (mode)
      SWAP_HALF: r = {w[23:16], w[31:24], w[7:0], w[15:8]};
      SWAP_WORD: r = {w[7:0], w[15:8], w[23:16], w[31:24]};
      default:   r = w;
    endcase
    return r;
  endfunction

  // One index through the primitive converter
  function automatic take_t take_index(prim_state_t st, logic [1:0] prim_mode,
                                       index_t v, logic fin);
    take_t r;
    r.st  = st;
    r.res = '0;
    case (prim_mode)
      PRIM_QUAD: begin
        if (st.fill == 2'(HOLD_DEPTH)) begin
          // quad complete: (a,b,c),(a,c,d)
          r.res.count  = CNT_W'(TRI_PAIR_SIZE);
          r.res.idx[0] = st.hold[0];
          r.res.idx[1] = st.hold[1];
          r.res.idx[2] = st.hold[2];
          r.res.idx[3] = st.hold[0];
          r.res.idx[4] = st.hold[2];
          r.res.idx[5] = v;
          r.res.eor[5] = fin;
          r.st.fill    = 2'd0;
        end else begin
          case (st.fill)
            2'd0:    r.st.hold[0] = v;
            2'd1:    r.st.hold[1] = v;
            default: r.st.hold[2] = v;
          endcase
          r.st.fill = st.fill + 2'd1;
        end
        if (fin) begin
          r.st.fill = 2'd0;
        end
      end
      PRIM_LOOP: begin
        if (!st.first_seen) begin
          r.st.loop_first = v;
          r.st.first_seen = 1'b1;
        end
        r.res.idx[0] = v;
        r.res.count  = CNT_W'(1);
        if (fin) begin
          // close the loop with its first index
          r.res.idx[1]    = r.st.loop_first;
          r.res.eor[1]    = 1'b1;
          r.res.count     = CNT_W'(2);
          r.st.first_seen = 1'b0;
        end
      end
      default: begin
        r.res.idx[0] = v;
        r.res.eor[0] = fin;
        r.res.count  = CNT_W'(1);
      end
    endcase
    return r;
  endfunction

  // Append the second group after the first
  function automatic batch_t merge_batches(batch_t a, batch_t b);
    batch_t           r;
    logic [CNT_W-1:0] pos;
    r = a;
    for (int j = 0; j < TRI_PAIR_SIZE; j++) begin
      pos = a.count + CNT_W'(j);
      if ((CNT_W'(j) < b.count) && (pos < CNT_W'(TRI_PAIR_SIZE))) begin
        r.idx[pos] = b.idx[j];
        r.eor[pos] = b.eor[j];
      end
    end
    r.count = a.count + b.count;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/isc_in_if.sv
// Input channel of index-buffer words.
// Depends on isc_pkg.
`default_nettype none

interface isc_in_if import isc_pkg::*; ;
  logic   valid;
  logic   ready;
  index_t word;
  logic   upper_valid;
  logic   last;

  modport source (output valid, word, upper_valid, last, input ready);
  modport sink   (input valid, word, upper_valid, last, output ready);
endinterface

`default_nettype wire

// File: rtl/isc_out_if.sv
// Result channel carrying converted indices.
// Depends on isc_pkg.
`default_nettype none

interface isc_out_if import isc_pkg::*; ;
  logic   valid;
  logic   ready;
  index_t index_out;
  logic   end_of_run;

  modport source (output valid, index_out, end_of_run, input ready);
  modport sink   (input valid, index_out, end_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/isc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on isc_pkg.
`default_nettype none

interface isc_cfg_if import isc_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/isc_cfg_regs.sv
// Configuration register bank for the converter.
// Depends on isc_pkg and isc_cfg_if.
`default_nettype none

module isc_cfg_regs import isc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  isc_cfg_if.sink    cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_INDEX_WIDE: regs.index_wide       <= cfg.data[0];
        REG_BYTE_ORDER: regs.byte_order       <= cfg.data[1:0];
        REG_PRIM_MODE:  regs.prim_mode        <= cfg.data[1:0];
        REG_GENERATE:   regs.generate_indices <= cfg.data[0];
        default:        regs                  <= regs;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/isc_expand.sv
// Input register, byte swap, index split and primitive expansion.
// Produces one group of up to six results per transaction.
// Depends on isc_pkg and isc_in_if.
`default_nettype none

module isc_expand import isc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  isc_in_if.sink    items,
  input  wire logic buf_free,
  output logic      batch_load,
  output batch_t    batch
);

  // input register
  logic   in_valid;
  index_t in_word;
  logic   in_upper;
  logic   in_last;

  // primitive state
  index_t [HOLD_DEPTH-1:0] hold;
  logic [1:0]              fill;
  index_t                  loop_first;
  logic                    first_seen;
  index_t                  vertex_count;

  prim_state_t st;
  prim_state_t st_next;
  index_t      vertex_count_next;
  index_t      swapped;
  index_t      v0;
  index_t      v1;
  logic        two;
  logic        fin0;
  take_t       t0;
  take_t       t1;

  assign items.ready = !in_valid || buf_free;
  assign batch_load  = in_valid && buf_free;

  assign st = '{hold: hold, fill: fill, loop_first: loop_first, first_seen: first_seen};

  // pick the indices carried by this transaction
  always_comb begin
    swapped = swap_word(in_word, cfg.byte_order);
    v1      = {{(IDX_W-HALF_W){1'b0}}, swapped[IDX_W-1:HALF_W]};
    two     = 1'b0;
    if (cfg.generate_indices) begin
      v0 = cfg.index_wide ? vertex_count
                          : {{(IDX_W-HALF_W){1'b0}}, vertex_count[HALF_W-1:0]};
    end else if (cfg.index_wide) begin
      v0 = swapped;
    end else begin
      v0  = {{(IDX_W-HALF_W){1'b0}}, swapped[HALF_W-1:0]};
      two = in_upper;
    end
    fin0 = two ? 1'b0 : in_last;
  end

  // expand up to two indices in order
  always_comb begin
    t0 = take_index(st, cfg.prim_mode, v0, fin0);
    t1 = take_index(t0.st, cfg.prim_mode, v1, in_last);
    if (two) begin
      batch   = merge_batches(t0.res, t1.res);
      st_next = t1.st;
    end else begin
      batch   = t0.res;
      st_next = t0.st;
    end
    if (cfg.generate_indices) begin
      vertex_count_next = cfg.index_wide ? vertex_count + 1'b1
        : {{(IDX_W-HALF_W){1'b0}}, vertex_count[HALF_W-1:0] + 1'b1};
    end else begin
      vertex_count_next = vertex_count;
    end
    // end of draw clears the run state
    if (in_last) begin
      st_next.fill       = 2'd0;
      st_next.first_seen = 1'b0;
      vertex_count_next  = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      fill         <= 2'd0;
      first_seen   <= 1'b0;
      vertex_count <= '0;
    end else begin
      if (items.valid && items.ready) begin
        in_valid <= 1'b1;
      end else if (batch_load) begin
        in_valid <= 1'b0;
      end
      if (batch_load) begin
        fill         <= st_next.fill;
        first_seen   <= st_next.first_seen;
        vertex_count <= vertex_count_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_word  <= items.word;
      in_upper <= items.upper_valid;
      in_last  <= items.last;
    end
    if (batch_load) begin
      hold       <= st_next.hold;
      loop_first <= st_next.loop_first;
    end
  end

endmodule

`default_nettype wire

// File: rtl/isc_res_buf.sv
// Result buffer: holds one group of results and shifts them out one a cycle while results.ready is high.
// Depends on isc_pkg and isc_out_if.
`default_nettype none

module isc_res_buf import isc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   batch_load,
  input  wire batch_t batch,
  output logic        buf_free,
  isc_out_if.source   results
);

  logic [CNT_W-1:0]           cnt;
  index_t [TRI_PAIR_SIZE-1:0] idx;
  logic [TRI_PAIR_SIZE-1:0]   eor;
  logic                       pop;

  assign results.valid      = (cnt != '0);
  assign results.index_out  = idx[0];
  assign results.end_of_run = eor[0];
  assign pop      = results.valid && results.ready;
  assign buf_free = (cnt == '0) || ((cnt == CNT_W'(1)) && pop);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (batch_load) begin
      cnt <= batch.count;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
    end
  end

  // entries: load a new group or shift towards the head
  always_ff @(posedge clk) begin
    if (batch_load) begin
      idx <= batch.idx;
      eor <= batch.eor;
    end else if (pop) begin
      for (int i = 0; i < TRI_PAIR_SIZE - 1; i++) begin
        idx[i] <= idx[i+1];
        eor[i] <= eor[i+1];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/index_stream_primitive_converter.sv
// Index stream primitive converter, top level.
// Path: an input transaction is held in the input register of isc_expand until
// the result buffer is free, then its group is loaded into the result buffer.
// Throughput: one transaction per cycle while each yields at most one result and
// the result port is ready; a transaction yielding more results holds back later
// transactions until its last result is taken at the one-per-cycle result port.
// Reset: synchronous, clears configuration registers, input valid, run state and buffer occupancy.
`default_nettype none

module index_stream_primitive_converter import isc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  isc_cfg_if.sink   cfg,
  isc_in_if.sink    items,
  isc_out_if.source results
);

  cfg_t   regs;
  batch_t batch;
  logic   batch_load;
  logic   buf_free;

  isc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  isc_expand u_expand (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .items      (items),
    .buf_free   (buf_free),
    .batch_load (batch_load),
    .batch      (batch)
  );

  isc_res_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .batch_load (batch_load),
    .batch      (batch),
    .buf_free   (buf_free),
    .results    (results)
  );

endmodule

`default_nettype wire
